>>> sv/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by the front end, the record queue, the back end and the top level.
`default_nettype none

package jsu_pkg;

  // Widths fixed by the interface.
  localparam int CNT_W  = 13;
  localparam int BYTE_W = 8;

  // Largest usable destination size; larger capacity settings act as this value.
  localparam int MAX_FIELD_BYTES = 4096;
  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(MAX_FIELD_BYTES);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

  // Default number of records held between front and back end.
  localparam int JSU_QUEUE_DEPTH = 4;

  // Input function codes.
  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_END   = 2'd1;
  localparam logic [1:0] FUNC_BEGIN = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;
  localparam logic [1:0] ERR_TYPE   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_WS_MODE  = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // Surrogate prefixes (top six bits of a 16-bit code unit).
  localparam logic [5:0] SUR_HIGH = 6'b110110;
  localparam logic [5:0] SUR_LOW  = 6'b110111;

  // Decoder phase.
  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_STR  = 4'd1,
    PH_ESC  = 4'd2,
    PH_HEX1 = 4'd3,
    PH_BSL  = 4'd4,
    PH_U    = 4'd5,
    PH_HEX2 = 4'd6,
    PH_DONE = 4'd7,
    PH_ERR  = 4'd8
  } phase_t;

  // Up to four encoded bytes; byte 0 goes out first.
  typedef struct packed {
    logic [2:0]             n;
    logic [3:0][BYTE_W-1:0] b;
  } utf8_t;

  // One accepted input item, as the back end needs it.
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [2:0]             n_store;
    logic [CNT_W-1:0]       base;
    logic                   done;
    logic [1:0]             err;
    logic                   trunc;
  } jsu_rec_t;

  // Encode a code point of up to 21 bits as UTF-8.
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.n    = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.n    = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/jsu_front.sv
// Front end of the JSON string unescaper: configuration registers, the decode
// state machine and capacity accounting. Depends on jsu_pkg.
`default_nettype none

module jsu_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [jsu_pkg::CNT_W-1:0] cfg_data,
  input  wire logic                    take,
  input  wire logic [1:0]              in_func,
  input  wire logic [7:0]              in_byte,
  output jsu_pkg::jsu_rec_t            rec
);
  import jsu_pkg::*;

  // Configuration and decoder state.
  logic             ws_mode_r;
  logic [CNT_W-1:0] cap_r;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [15:0]      hex_r, hex_nxt;
  logic [9:0]       high_r, high_nxt;
  logic [1:0]       digits_r, digits_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;

  // Classification of the current byte.
  logic        is_ws;
  logic        nib_ok;
  logic [3:0]  nib_val;
  logic [15:0] hex_new;
  logic        hex_done;
  logic        new_hi_sur;
  logic        new_lo_sur;

  // Bytes produced by this item before capacity limits.
  utf8_t            em;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W:0]   avail;
  logic [2:0]       n_store;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_mode_r <= 1'b0;
      cap_r     <= CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WS_MODE) ws_mode_r <= cfg_data[0];
      if (cfg_index == CFG_CAPACITY) cap_r <= cfg_data;
    end
  end

  // Hex digit decode and surrogate checks on the value the digit completes.
  always_comb begin
    is_ws = (in_byte == CH_SPACE) || (in_byte == CH_LF) ||
            (in_byte == CH_CR) || (in_byte == CH_TAB);
    nib_ok  = 1'b1;
    nib_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      nib_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      nib_val = in_byte[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
    hex_new    = {hex_r[11:0], nib_val};
    hex_done   = (digits_r == 2'd3);
    new_hi_sur = (hex_new[15:10] == SUR_HIGH);
    new_lo_sur = (hex_new[15:10] == SUR_LOW);
  end

  // Next-state logic of the decoder.
  always_comb begin
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    hex_nxt    = hex_r;
    high_nxt   = high_r;
    digits_nxt = digits_r;
    unique case (in_func)
      FUNC_DATA: begin
        unique case (phase_r)
          PH_WAIT: begin
            if (!is_ws) begin
              if (in_byte == CH_QUOTE) begin
                phase_nxt = PH_STR;
              end else begin
                phase_nxt = PH_ERR;
                err_nxt   = ERR_TYPE;
              end
            end
          end
          PH_STR: begin
            if (in_byte == CH_QUOTE) begin
              phase_nxt = PH_DONE;
            end else if (in_byte < CH_SPACE) begin
              phase_nxt = PH_ERR;
              err_nxt   = ERR_SYNTAX;
            end else if (in_byte == CH_BSL) begin
              phase_nxt = PH_ESC;
            end
          end
          PH_ESC: begin
            unique case (in_byte)
              CH_U: begin
                phase_nxt  = PH_HEX1;
                hex_nxt    = 16'd0;
                digits_nxt = 2'd0;
              end
              CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
                phase_nxt = PH_STR;
              end
              default: begin
                phase_nxt = PH_ERR;
                err_nxt   = ERR_SYNTAX;
              end
            endcase
          end
          PH_HEX1, PH_HEX2: begin
            if (!nib_ok) begin
              phase_nxt = PH_ERR;
              err_nxt   = ERR_SYNTAX;
            end else begin
              hex_nxt = hex_new;
              if (!hex_done) begin
                digits_nxt = digits_r + 2'd1;
              end else begin
                digits_nxt = 2'd0;
                if (phase_r == PH_HEX1) begin
                  if (new_hi_sur) begin
                    high_nxt  = hex_new[9:0];
                    phase_nxt = PH_BSL;
                  end else if (new_lo_sur || hex_new == 16'd0) begin
                    phase_nxt = PH_ERR;
                    err_nxt   = ERR_SYNTAX;
                  end else begin
                    phase_nxt = PH_STR;
                  end
                end else if (new_lo_sur) begin
                  phase_nxt = PH_STR;
                end else begin
                  phase_nxt = PH_ERR;
                  err_nxt   = ERR_SYNTAX;
                end
              end
            end
          end
          PH_BSL: begin
            if (in_byte == CH_BSL) begin
              phase_nxt = PH_U;
            end else begin
              phase_nxt = PH_ERR;
              err_nxt   = ERR_SYNTAX;
            end
          end
          PH_U: begin
            if (in_byte == CH_U) begin
              phase_nxt  = PH_HEX2;
              hex_nxt    = 16'd0;
              digits_nxt = 2'd0;
            end else begin
              phase_nxt = PH_ERR;
              err_nxt   = ERR_SYNTAX;
            end
          end
          default: ;
        endcase
      end
      FUNC_END: begin
        if (phase_r == PH_WAIT) begin
          phase_nxt = PH_ERR;
          err_nxt   = ERR_TYPE;
        end else if (phase_r != PH_DONE && phase_r != PH_ERR) begin
          phase_nxt = PH_ERR;
          err_nxt   = ERR_SYNTAX;
        end
      end
      FUNC_BEGIN: begin
        phase_nxt  = PH_WAIT;
        err_nxt    = ERR_NONE;
        hex_nxt    = 16'd0;
        high_nxt   = 10'd0;
        digits_nxt = 2'd0;
      end
      default: ;
    endcase
  end

  // Output logic of the decoder: the bytes this item produces.
  always_comb begin
    em = '0;
    if (in_func == FUNC_DATA) begin
      unique case (phase_r)
        PH_STR: begin
          if (in_byte != CH_QUOTE && in_byte >= CH_SPACE && in_byte != CH_BSL) begin
            em.n    = 3'd1;
            em.b[0] = in_byte;
          end
        end
        PH_ESC: begin
          em.n = 3'd1;
          unique case (in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: em.b[0] = in_byte;
            CH_B:    em.b[0] = CH_BS;
            CH_F:    em.b[0] = CH_FF;
            CH_N:    em.b[0] = ws_mode_r ? CH_SPACE : CH_LF;
            CH_R:    em.b[0] = ws_mode_r ? CH_SPACE : CH_CR;
            CH_T:    em.b[0] = ws_mode_r ? CH_SPACE : CH_TAB;
            default: em.n = 3'd0;
          endcase
        end
        PH_HEX1: begin
          if (nib_ok && hex_done && !new_hi_sur && !new_lo_sur && hex_new != 16'd0) begin
            em = utf8_encode({5'd0, hex_new});
          end
        end
        PH_HEX2: begin
          if (nib_ok && hex_done && new_lo_sur) begin
            em = utf8_encode({11'({1'b0, high_r}) + 11'd64, hex_new[9:0]});
          end
        end
        default: ;
      endcase
    end
  end

  // Capacity: keep bytes while the stored count plus one stays below the limit.
  always_comb begin
    cap_eff = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
    avail   = {1'b0, cap_eff} - {1'b0, count_r} - {{CNT_W{1'b0}}, 1'b1};
    if (avail[CNT_W]) begin
      n_store = 3'd0;
    end else if (avail >= (CNT_W+1)'(em.n)) begin
      n_store = em.n;
    end else begin
      n_store = avail[2:0];
    end
    if (in_func == FUNC_BEGIN) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end else begin
      count_nxt   = count_r + CNT_W'(n_store);
      dropped_nxt = dropped_r | (n_store != em.n);
    end
  end

  // Record handed to the queue.
  always_comb begin
    rec.bytes   = em.b;
    rec.n_store = (in_func == FUNC_BEGIN) ? 3'd0 : n_store;
    rec.base    = (in_func == FUNC_BEGIN) ? '0 : count_r;
    rec.done    = (phase_nxt == PH_DONE);
    rec.err     = err_nxt;
    rec.trunc   = dropped_nxt;
  end

  // Decoder state update on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      err_r     <= ERR_NONE;
      hex_r     <= 16'd0;
      high_r    <= 10'd0;
      digits_r  <= 2'd0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      err_r     <= err_nxt;
      hex_r     <= hex_nxt;
      high_r    <= high_nxt;
      digits_r  <= digits_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/jsu_fifo.sv
// Short record queue between the front end and the back end of the unescaper.
// Register storage with one read port at the head. Depends on jsu_pkg.
`default_nettype none

module jsu_fifo #(
  parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  jsu_pkg::jsu_rec_t push_rec,
  input  wire logic         pop,
  output jsu_pkg::jsu_rec_t head_rec,
  output logic              full,
  output logic              empty
);
  import jsu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_Q = $clog2(DEPTH + 1);

  jsu_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_Q-1:0] count_r;

  assign full     = (count_r == CNT_Q'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_rec = mem_r[rd_ptr_r];

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop) count_r <= count_r + CNT_Q'(1);
      else if (pop && !push) count_r <= count_r - CNT_Q'(1);
    end
  end

endmodule

`default_nettype wire

>>> sv/jsu_back.sv
// Back end of the unescaper: expands each queued record into one result per
// stored byte, or a single status result. Depends on jsu_pkg.
`default_nettype none

module jsu_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  jsu_pkg::jsu_rec_t              head_rec,
  input  wire logic                      empty,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_done_res,
  output logic [1:0]                     out_error_code,
  output logic                           out_truncated,
  output logic [jsu_pkg::CNT_W-1:0]      out_length,
  output logic                           out_last
);
  import jsu_pkg::*;

  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       xfer;

  // Present the head record's current byte.
  always_comb begin
    last_idx       = (head_rec.n_store == 3'd0) ? 2'd0 : 2'(head_rec.n_store - 3'd1);
    out_valid      = !empty;
    out_byte_valid = (head_rec.n_store != 3'd0);
    out_byte       = out_byte_valid ? head_rec.bytes[idx_r] : 8'd0;
    out_length     = out_byte_valid ? head_rec.base + CNT_W'(idx_r) + CNT_W'(1)
                                    : head_rec.base;
    out_done_res   = head_rec.done;
    out_error_code = head_rec.err;
    out_truncated  = head_rec.trunc;
    out_last       = (idx_r == last_idx);
    xfer           = out_valid && !out_stall;
    pop            = xfer && out_last;
  end

  // Byte index within the head record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (xfer) begin
      idx_r <= out_last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/json_string_unescaper_core.sv
// JSON string unescaper: takes one byte per transfer (func 0 data, 1 end of
// data, 2 begin new string) and decodes a quoted JSON string, including \u
// escapes and surrogate pairs, into UTF-8 result bytes with running length,
// done, error and truncation status. A new input is accepted every cycle while
// the record queue (QUEUE_DEPTH entries) has room; results leave one per cycle
// while out_stall is low, so an input that stores k bytes (0 to 4) yields
// max(k, 1) results, and the output port sets the sustained rate. When the queue
// is empty, the first result of an input is valid in the cycle after its
// acceptance; otherwise it waits behind the results already queued. Depends on
// jsu_pkg, jsu_front, jsu_fifo and jsu_back.
`default_nettype none

module json_string_unescaper_core #(
  parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [jsu_pkg::CNT_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_func,
  input  wire logic [7:0]                in_byte,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_done_res,
  output logic [1:0]                     out_error_code,
  output logic                           out_truncated,
  output logic [jsu_pkg::CNT_W-1:0]      out_length,
  output logic                           out_last
);
  import jsu_pkg::*;

  jsu_rec_t rec, head_rec;
  logic     take, pop, full, empty;

  // Accept an input whenever the queue has room.
  assign in_stall = full;
  assign take     = in_valid && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_func   (in_func),
    .in_byte   (in_byte),
    .rec       (rec)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_rec (rec),
    .pop      (pop),
    .head_rec (head_rec),
    .full     (full),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_rec       (head_rec),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_error_code (out_error_code),
    .out_truncated  (out_truncated),
    .out_length     (out_length),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A status result without a byte is always the only result of its input.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_last)
    else $error("status result not marked last");

  // Results within one input carry consecutive lengths.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && out_byte_valid && out_length == $past(out_length) + 13'd1))
    else $error("length did not advance within an input");

  // A stored byte always counts toward the length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_valid) |-> (out_length != 13'd0))
    else $error("stored byte with zero length");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_json_string_unescaper_core.sv
// Self-checking testbench for json_string_unescaper_core: random JSON string streams.
// Results are predicted per accepted byte and compared in order. Needs jsu_pkg and the core.
`timescale 1ns / 100ps

module tb_json_string_unescaper_core;
  import jsu_pkg::*;

  // The func encoding has one value that is never named by the block.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // One input transfer.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
  } feed_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0]       data;
    logic             stored;
    logic             done;
    logic [1:0]       err;
    logic             trunc;
    logic [CNT_W-1:0] len;
    logic             last;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_func = FUNC_DATA;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             out_byte_valid;
  logic             out_done_res;
  logic [1:0]       out_error_code;
  logic             out_truncated;
  logic [CNT_W-1:0] out_length;
  logic             out_last;

  json_string_unescaper_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_error_code (out_error_code),
    .out_truncated  (out_truncated),
    .out_length     (out_length),
    .out_last       (out_last)
  );

  always #1 clk = ~clk;

  // Stimulus and expectation stores.
  feed_t   feed_q[$];
  result_t decoded_q[$];
  feed_t   next_feed;

  // Idle control shared between the stimulus sequence and the two channel processes.
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int hold_req = 0;
  int gap_left = 0;
  int stall_left = 0;

  // Bookkeeping.
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_fail = 0;
  int n_cfg_writes = 0;
  int n_settings = 0;
  int n_done_seen = 0;
  int n_syntax_seen = 0;
  int n_type_seen = 0;
  int n_trunc_seen = 0;

  // Decoder state as the testbench tracks it.
  logic             ws_mode_reg;
  logic [CNT_W-1:0] capacity_reg;
  phase_t           m_phase;
  logic [15:0]      m_hex;
  logic [9:0]       m_high;
  logic [1:0]       m_digits;
  logic [CNT_W-1:0] m_count;
  logic             m_trunc;
  logic [1:0]       m_err;

  // Bytes stored by the transfer being decoded.
  logic [7:0]       emit_byte [4];
  logic [CNT_W-1:0] emit_len  [4];
  int               emit_n;

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'(8'h30);
    if (c >= "a" && c <= "f") return int'(c) - int'(8'h61) + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'(8'h41) + 10;
    return -1;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSL || c == CH_SLASH || c == CH_B || c == CH_F ||
           c == CH_N || c == CH_R || c == CH_T || c == CH_U;
  endfunction

  function automatic void start_new_string();
    m_phase  = PH_WAIT;
    m_hex    = '0;
    m_high   = '0;
    m_digits = '0;
    m_count  = '0;
    m_trunc  = 1'b0;
    m_err    = ERR_NONE;
  endfunction

  function automatic void enter_error(logic [1:0] code);
    m_err   = code;
    m_phase = PH_ERR;
  endfunction

  // Keep a byte while the count plus the terminator fits, otherwise flag the loss.
  function automatic void store_byte(logic [7:0] b);
    int cap;
    cap = (capacity_reg > CAP_LIMIT) ? MAX_FIELD_BYTES : int'(capacity_reg);
    if (int'(m_count) + 1 < cap && emit_n < 4) begin
      m_count++;
      emit_byte[emit_n] = b;
      emit_len[emit_n]  = m_count;
      emit_n++;
    end else begin
      m_trunc = 1'b1;
    end
  endfunction

  function automatic void store_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      store_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      store_byte(8'hC0 | 8'(cp >> 6));
      store_byte(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      store_byte(8'hE0 | 8'(cp >> 12));
      store_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      store_byte(8'h80 | 8'(cp & 21'h3F));
    end else begin
      store_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
      store_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
      store_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      store_byte(8'h80 | 8'(cp & 21'h3F));
    end
  endfunction

  // Returns 1 when the fourth hex digit has just completed a code unit.
  function automatic bit hex_shift_in(logic [7:0] c);
    int v;
    v = hex_digit_value(c);
    if (v < 0) begin
      enter_error(ERR_SYNTAX);
      return 1'b0;
    end
    m_hex = {m_hex[11:0], 4'(v)};
    if (m_digits == 2'd3) begin
      m_digits = 2'd0;
      return 1'b1;
    end
    m_digits++;
    return 1'b0;
  endfunction

  function automatic void unescape_data_byte(logic [7:0] c);
    case (m_phase)
      PH_WAIT: begin
        if (is_space(c)) return;
        if (c == CH_QUOTE) m_phase = PH_STR;
        else enter_error(ERR_TYPE);
      end
      PH_STR: begin
        if (c == CH_QUOTE) m_phase = PH_DONE;
        else if (c < CH_SPACE) enter_error(ERR_SYNTAX);
        else if (c == CH_BSL) m_phase = PH_ESC;
        else store_byte(c);
      end
      PH_ESC: begin
        m_phase = PH_STR;
        case (c)
          CH_QUOTE, CH_BSL, CH_SLASH: store_byte(c);
          CH_B: store_byte(CH_BS);
          CH_F: store_byte(CH_FF);
          CH_N: store_byte(ws_mode_reg ? CH_SPACE : CH_LF);
          CH_R: store_byte(ws_mode_reg ? CH_SPACE : CH_CR);
          CH_T: store_byte(ws_mode_reg ? CH_SPACE : CH_TAB);
          CH_U: begin
            m_hex    = '0;
            m_digits = '0;
            m_phase  = PH_HEX1;
          end
          default: enter_error(ERR_SYNTAX);
        endcase
      end
      PH_HEX1: begin
        if (!hex_shift_in(c)) return;
        if (m_hex[15:10] == SUR_HIGH) begin
          m_high  = m_hex[9:0];
          m_phase = PH_BSL;
        end else if (m_hex[15:10] == SUR_LOW || m_hex == 16'h0000) begin
          enter_error(ERR_SYNTAX);
        end else begin
          store_code_point({5'd0, m_hex});
          m_phase = PH_STR;
        end
      end
      PH_BSL: begin
        if (c == CH_BSL) m_phase = PH_U;
        else enter_error(ERR_SYNTAX);
      end
      PH_U: begin
        if (c == CH_U) begin
          m_hex    = '0;
          m_digits = '0;
          m_phase  = PH_HEX2;
        end else begin
          enter_error(ERR_SYNTAX);
        end
      end
      PH_HEX2: begin
        if (!hex_shift_in(c)) return;
        if (m_hex[15:10] != SUR_LOW) begin
          enter_error(ERR_SYNTAX);
        end else begin
          store_code_point(21'h10000 + {1'b0, m_high, m_hex[9:0]});
          m_phase = PH_STR;
        end
      end
      default: ;
    endcase
  endfunction

  // Works out the result transfers of one accepted input transfer.
  function automatic void unescape_step(logic [1:0] f, logic [7:0] c);
    result_t r;
    int      n;
    emit_n = 0;
    case (f)
      FUNC_DATA: unescape_data_byte(c);
      FUNC_END: begin
        if (m_phase == PH_WAIT) enter_error(ERR_TYPE);
        else if (m_phase != PH_DONE && m_phase != PH_ERR) enter_error(ERR_SYNTAX);
      end
      FUNC_BEGIN: start_new_string();
      default: ;
    endcase
    n = (emit_n > 0) ? emit_n : 1;
    for (int k = 0; k < n; k++) begin
      r.stored = emit_n > 0;
      r.data   = (emit_n > 0) ? emit_byte[k] : 8'h00;
      r.len    = (emit_n > 0) ? emit_len[k] : m_count;
      r.done   = m_phase == PH_DONE;
      r.err    = m_err;
      r.trunc  = m_trunc;
      r.last   = k == n - 1;
      decoded_q.push_back(r);
    end
  endfunction

  // Mostly short gaps, a few long ones, none while idling is switched off.
  function automatic int idle_len(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sender: presents queued items, tracks the decoder on every accepted transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_func      <= FUNC_DATA;
      in_byte      <= 8'h00;
      gap_left     = 0;
      ws_mode_reg  = 1'b0;
      capacity_reg = CAP_RESET;
      start_new_string();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WS_MODE) ws_mode_reg = cfg_data[0];
        else capacity_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        unescape_step(in_func, in_byte);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          next_feed = feed_q.pop_front();
          in_valid  <= 1'b1;
          in_func   <= next_feed.func;
          in_byte   <= next_feed.data;
          gap_left  = idle_len(send_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_result();
    result_t e;
    n_results++;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, actual byte %0h",
               $time, out_byte);
      n_fail++;
    end else begin
      e = decoded_q.pop_front();
      check_field("out_byte", e.data, out_byte);
      check_field("out_byte_valid", e.stored, out_byte_valid);
      check_field("out_done_res", e.done, out_done_res);
      check_field("out_error_code", e.err, out_error_code);
      check_field("out_truncated", e.trunc, out_truncated);
      check_field("out_length", e.len, out_length);
      check_field("out_last", e.last, out_last);
    end
    if (out_last) begin
      if (out_done_res) n_done_seen++;
      if (out_error_code == ERR_SYNTAX) n_syntax_seen++;
      if (out_error_code == ERR_TYPE) n_type_seen++;
      if (out_truncated) n_trunc_seen++;
    end
  endtask

  // Receiver: checks accepted results and decides its own stalls, long holds included.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left == 0) stall_left = idle_len(recv_idle_on);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus building blocks.
  task automatic put_item(logic [1:0] f, logic [7:0] b);
    feed_t it;
    it.func = f;
    it.data = b;
    feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic put_char(logic [7:0] b);
    put_item(FUNC_DATA, b);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic put_uesc(logic [15:0] v);
    put_char(CH_BSL);
    put_char(CH_U);
    for (int i = 3; i >= 0; i--) put_char(hex_char(v[4*i +: 4]));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // A basic-plane value outside the surrogates and never zero; ends of each UTF-8 band too.
  function automatic logic [15:0] bmp_value();
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: v = 16'($urandom_range(1, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      2: v = 16'($urandom_range(16'h800, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 5))
          0: v = 16'h0001;
          1: v = 16'h007F;
          2: v = 16'h0080;
          3: v = 16'h07FF;
          4: v = 16'h0800;
          default: v = 16'hFFFF;
        endcase
      end
    endcase
    if (v[15:11] == 5'b11011) v = v ^ 16'h2000;
    return v;
  endfunction

  function automatic logic [9:0] surrogate_half();
    case ($urandom_range(0, 5))
      0: return 10'h000;
      1: return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  task automatic put_body_token();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      put_char(plain_byte());
    end else if (kind < 6) begin
      put_char(CH_BSL);
      put_char(simple_escape());
    end else if (kind < 9) begin
      put_uesc(bmp_value());
    end else begin
      put_uesc({SUR_HIGH, surrogate_half()});
      put_uesc({SUR_LOW, surrogate_half()});
    end
  endtask

  // Bytes after a finished or failed string; the block must leave its status alone.
  task automatic put_trailing();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) put_item(FUNC_END, 8'($urandom));
      else put_char(8'($urandom));
    end
  endtask

  // A string that goes wrong in one of the ways the decoder must reject.
  task automatic put_broken_tail();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(0, 8))
      0: put_item(FUNC_END, 8'($urandom));
      1: begin
        // Unknown escape letter.
        do c = 8'($urandom); while (is_escape_char(c));
        put_char(CH_BSL);
        put_char(c);
      end
      2: begin
        // Bad hex digit at a random position.
        put_char(CH_BSL);
        put_char(CH_U);
        repeat ($urandom_range(0, 3)) put_char(hex_char(4'($urandom)));
        do c = 8'($urandom); while (hex_digit_value(c) >= 0);
        put_char(c);
      end
      3: put_uesc(16'h0000);
      4: put_uesc({SUR_LOW, surrogate_half()});
      5: begin
        // High half followed by something other than a backslash.
        put_uesc({SUR_HIGH, surrogate_half()});
        do c = 8'($urandom); while (c == CH_BSL);
        put_char(c);
      end
      6: begin
        // High half, backslash, then not a u.
        put_uesc({SUR_HIGH, surrogate_half()});
        put_char(CH_BSL);
        do c = 8'($urandom); while (c == CH_U);
        put_char(c);
      end
      7: begin
        // High half followed by an escape that is not a low half.
        put_uesc({SUR_HIGH, surrogate_half()});
        do v = 16'($urandom); while (v[15:10] == SUR_LOW);
        put_uesc(v);
      end
      default: put_char(8'($urandom_range(0, 31)));
    endcase
    if ($urandom_range(0, 1)) put_trailing();
  endtask

  // Mostly well-formed strings with random content, some broken ones and some noise.
  task automatic put_string();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) put_item(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    if (r < 95) put_item(FUNC_BEGIN, 8'($urandom));
    repeat ($urandom_range(0, 2)) put_char(space_byte());
    r = $urandom_range(0, 99);
    if (r < 4) begin
      put_item(FUNC_END, 8'($urandom));
      return;
    end
    if (r < 9) begin
      do c = 8'($urandom); while (c == CH_QUOTE || is_space(c));
      put_char(c);
      put_trailing();
      return;
    end
    put_char(CH_QUOTE);
    repeat ($urandom_range(0, 6)) put_body_token();
    if ($urandom_range(0, 99) < 75) begin
      put_char(CH_QUOTE);
      if ($urandom_range(0, 3) == 0) put_trailing();
    end else begin
      put_broken_tail();
    end
  endtask

  task automatic fill_random(int n_items);
    int target;
    target = n_queued + n_items;
    while (n_queued < target) put_string();
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg_writes++;
  endtask

  // Registers change only once the block has gone quiet.
  task automatic apply_setting(bit ws, logic [CNT_W-1:0] cap, bit snd_idle, bit rcv_idle,
                               int hold);
    wait_drained();
    write_reg(CFG_WS_MODE, {12'($urandom), ws});
    write_reg(CFG_CAPACITY, cap);
    n_settings++;
    send_idle_on = snd_idle;
    recv_idle_on = rcv_idle;
    hold_req     = hold;
  endtask

  // Directed opening: whitespace, extreme bytes, zero code point, sticky error,
  // missing quote, early end, control byte, spare func and input after the close.
  task automatic put_directed();
    put_item(FUNC_BEGIN, 8'h00);
    put_char(CH_SPACE);
    put_char(CH_TAB);
    put_char(CH_QUOTE);
    put_char("A");
    put_char(8'hFF);
    put_char(CH_BSL);
    put_char(CH_N);
    put_uesc(16'h0000);
    put_item(FUNC_END, 8'hFF);
    put_char(8'h00);
    put_item(FUNC_BEGIN, 8'hFF);
    put_char("x");
    put_item(FUNC_BEGIN, 8'h00);
    put_item(FUNC_END, 8'h00);
    put_item(FUNC_BEGIN, 8'h00);
    put_char(CH_QUOTE);
    put_char(8'h1F);
    put_item(FUNC_SPARE, 8'hFF);
    put_item(FUNC_BEGIN, 8'h00);
    put_char(CH_QUOTE);
    put_char(CH_QUOTE);
    put_item(FUNC_END, 8'h00);
  endtask

  // Main sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    apply_setting(1'b0, CAP_RESET, 1'b1, 1'b1, 0);
    put_directed();
    fill_random(85);
    // Long receiver hold while the sender streams without gaps.
    apply_setting(1'b1, 13'h1FFF, 1'b0, 1'b1, 70);
    fill_random(45);
    apply_setting(1'b0, 13'd0, 1'b1, 1'b1, 0);
    fill_random(20);
    apply_setting(1'b1, 13'd1, 1'b1, 1'b0, 0);
    fill_random(20);
    apply_setting(1'b0, 13'd2, 1'b0, 1'b1, 0);
    fill_random(30);
    apply_setting(1'b1, 13'd7, 1'b1, 1'b1, 0);
    fill_random(40);
    apply_setting(1'b1, CAP_LIMIT, 1'b0, 1'b0, 0);
    fill_random(42);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input transfers and %0d result transfers, %0d register writes",
             n_accepted, n_results, n_cfg_writes);
    $display("over %0d settings; inputs ending closed %0d, syntax %0d, type %0d, truncated %0d.",
             n_settings, n_done_seen, n_syntax_seen, n_type_seen, n_trunc_seen);
    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("PASS json_string_unescaper_core");
    end else begin
      $display("FAIL json_string_unescaper_core");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_000_000;
    $display("Timeout with %0d results still expected.", decoded_q.size());
    $display("FAIL json_string_unescaper_core");
    $finish;
  end

endmodule
